// ----- rtl/gaps_pkg.sv -----
package gaps_pkg;

   localparam int MAX_SIDE_DEF   = 32;
   localparam int COST_WIDTH_DEF = 16;
   localparam int SIZE_W         = 6;
   localparam int SIZE_RESET     = 20;
   localparam int STEP_STRAIGHT  = 10;
   localparam int STEP_DIAG      = 14;
   localparam int HEUR_SCALE     = 10;
   localparam int IN_CRD_W       = 5;
   localparam int OUT_COST_W     = 16;
   localparam int REQ_DATA_W     = 24;
   localparam int RSP_DATA_W     = 16;
   localparam int CSR_ADDR_W     = 1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_GRID_ROWS = 1'b0,
      REG_GRID_COLS = 1'b1
   } reg_index_type;

   typedef enum logic {
      REQ_WRITE  = 1'b0,
      REQ_SEARCH = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      RES_WRITE_DONE = 2'd0,
      RES_FOUND      = 2'd1,
      RES_NO_PATH    = 2'd2
   } result_type;

   typedef enum logic [4:0] {
      S_RST_CLR, S_IDLE, S_LOAD, S_WRMAP, S_CLEAR, S_INIT, S_GOAL_CHK,
      S_NB_START, S_NB_RD1, S_NB_RD2, S_NB_RD3, S_NB_EVAL, S_NB_NEXT,
      S_CLOSE, S_SCAN_L, S_SCAN_E, S_SCAN_C, S_MV_INIT, S_MV_CHK, S_MV_RD,
      S_MV_WR, S_POP, S_POP_WT, S_FIN_WR, S_FIN_OK, S_FIN_NONE
   } state_type;

   typedef struct packed {
      logic       clr_step;
      logic       clr_blk;
      logic       wr_map;
      logic       init_start;
      logic       nb_first;
      logic       rd1;
      logic       rd2;
      logic       rd3;
      logic       eval;
      logic       nb_next;
      logic       close_cur;
      logic       scan_init;
      logic       scan_l;
      logic       scan_e;
      logic       scan_c;
      logic       mv_init;
      logic       mv_rd;
      logic       mv_wr;
      logic       pop;
      logic       pop_wt;
      logic       out_load;
      result_type out_code;
   } cmd_type;

   typedef struct packed {
      logic is_search;
      logic off_grid;
      logic clr_last;
      logic at_goal;
      logic nb_ok;
      logic nb_last;
      logic open_empty;
      logic scan_last;
      logic mv_end;
      logic out_free;
   } stat_type;

endpackage

// ----- rtl/gaps_ctrl.sv -----
module gaps_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  gaps_pkg::stat_type stat,
   output gaps_pkg::cmd_type  cmd
);

   gaps_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gaps_pkg::S_RST_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         gaps_pkg::S_RST_CLR: begin
            cmd.clr_step = 1'b1;
            cmd.clr_blk  = 1'b1;
            if (stat.clr_last) state_in = gaps_pkg::S_IDLE;
         end
         gaps_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) state_in = gaps_pkg::S_LOAD;
         end
         gaps_pkg::S_LOAD: begin
            if (!stat.is_search) state_in = gaps_pkg::S_WRMAP;
            else if (stat.off_grid) state_in = gaps_pkg::S_FIN_NONE;
            else state_in = gaps_pkg::S_CLEAR;
         end
         gaps_pkg::S_WRMAP: begin
            cmd.wr_map = 1'b1;
            state_in   = gaps_pkg::S_FIN_WR;
         end
         gaps_pkg::S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) state_in = gaps_pkg::S_INIT;
         end
         gaps_pkg::S_INIT: begin
            cmd.init_start = 1'b1;
            state_in       = gaps_pkg::S_GOAL_CHK;
         end
         gaps_pkg::S_GOAL_CHK: begin
            if (stat.at_goal) begin
               state_in = gaps_pkg::S_FIN_OK;
            end else begin
               cmd.nb_first = 1'b1;
               state_in     = gaps_pkg::S_NB_START;
            end
         end
         gaps_pkg::S_NB_START: begin
            state_in = stat.nb_ok ? gaps_pkg::S_NB_RD1 : gaps_pkg::S_NB_NEXT;
         end
         gaps_pkg::S_NB_RD1: begin
            cmd.rd1  = 1'b1;
            state_in = gaps_pkg::S_NB_RD2;
         end
         gaps_pkg::S_NB_RD2: begin
            cmd.rd2  = 1'b1;
            state_in = gaps_pkg::S_NB_RD3;
         end
         gaps_pkg::S_NB_RD3: begin
            cmd.rd3  = 1'b1;
            state_in = gaps_pkg::S_NB_EVAL;
         end
         gaps_pkg::S_NB_EVAL: begin
            cmd.eval = 1'b1;
            state_in = gaps_pkg::S_NB_NEXT;
         end
         gaps_pkg::S_NB_NEXT: begin
            if (stat.nb_last) begin
               state_in = gaps_pkg::S_CLOSE;
            end else begin
               cmd.nb_next = 1'b1;
               state_in    = gaps_pkg::S_NB_START;
            end
         end
         gaps_pkg::S_CLOSE: begin
            cmd.close_cur = 1'b1;
            if (stat.open_empty) begin
               state_in = gaps_pkg::S_FIN_NONE;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = gaps_pkg::S_SCAN_L;
            end
         end
         gaps_pkg::S_SCAN_L: begin
            cmd.scan_l = 1'b1;
            state_in   = gaps_pkg::S_SCAN_E;
         end
         gaps_pkg::S_SCAN_E: begin
            cmd.scan_e = 1'b1;
            state_in   = gaps_pkg::S_SCAN_C;
         end
         gaps_pkg::S_SCAN_C: begin
            cmd.scan_c = 1'b1;
            state_in   = stat.scan_last ? gaps_pkg::S_MV_INIT : gaps_pkg::S_SCAN_L;
         end
         gaps_pkg::S_MV_INIT: begin
            cmd.mv_init = 1'b1;
            state_in    = gaps_pkg::S_MV_CHK;
         end
         gaps_pkg::S_MV_CHK: begin
            state_in = stat.mv_end ? gaps_pkg::S_POP : gaps_pkg::S_MV_RD;
         end
         gaps_pkg::S_MV_RD: begin
            cmd.mv_rd = 1'b1;
            state_in  = gaps_pkg::S_MV_WR;
         end
         gaps_pkg::S_MV_WR: begin
            cmd.mv_wr = 1'b1;
            state_in  = gaps_pkg::S_MV_CHK;
         end
         gaps_pkg::S_POP: begin
            cmd.pop  = 1'b1;
            state_in = gaps_pkg::S_POP_WT;
         end
         gaps_pkg::S_POP_WT: begin
            cmd.pop_wt = 1'b1;
            state_in   = gaps_pkg::S_GOAL_CHK;
         end
         gaps_pkg::S_FIN_WR: begin
            cmd.out_code = gaps_pkg::RES_WRITE_DONE;
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = gaps_pkg::S_IDLE;
            end
         end
         gaps_pkg::S_FIN_OK: begin
            cmd.out_code = gaps_pkg::RES_FOUND;
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = gaps_pkg::S_IDLE;
            end
         end
         gaps_pkg::S_FIN_NONE: begin
            cmd.out_code = gaps_pkg::RES_NO_PATH;
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = gaps_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = gaps_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/gaps_datapath.sv -----
module gaps_datapath #(
   parameter int MAX_SIDE   = gaps_pkg::MAX_SIDE_DEF,
   parameter int COST_WIDTH = gaps_pkg::COST_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_load,
   input  logic [gaps_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [gaps_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [1:0]                          rsp_tuser,
   input  logic                                csr_we,
   input  logic [gaps_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [gaps_pkg::SIZE_W-1:0]         csr_wdata,
   input  gaps_pkg::cmd_type                   cmd,
   output gaps_pkg::stat_type                  stat
);

   localparam int IDX_W  = $clog2(MAX_SIDE);
   localparam int CW     = (IDX_W + 2 > 6) ? IDX_W + 2 : 6;
   localparam int CELLS  = MAX_SIDE * MAX_SIDE;
   localparam int AW     = $clog2(CELLS);
   localparam int CNT_W  = AW + 1;
   localparam int HW     = CW + 5;
   localparam int SW     = ((COST_WIDTH > HW) ? COST_WIDTH : HW) + 1;
   localparam int LW     = 2 * IDX_W;
   localparam int SZW    = gaps_pkg::SIZE_W + 1;

   function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
      cell_addr = AW'(AW'(r) * AW'(MAX_SIDE)) + AW'(c);
   endfunction

   function automatic logic [COST_WIDTH-1:0] sat_cost(input logic [SW-1:0] v);
      sat_cost = (v > SW'({COST_WIDTH{1'b1}})) ? {COST_WIDTH{1'b1}} : v[COST_WIDTH-1:0];
   endfunction

   // Size registers and clamped sizes.
   logic [gaps_pkg::SIZE_W-1:0] rows_ff, cols_ff;
   logic [CW-1:0]               rows_eff, cols_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= gaps_pkg::SIZE_W'(gaps_pkg::SIZE_RESET);
         cols_ff <= gaps_pkg::SIZE_W'(gaps_pkg::SIZE_RESET);
      end else if (csr_we) begin
         if (csr_addr == gaps_pkg::REG_GRID_ROWS) rows_ff <= csr_wdata;
         if (csr_addr == gaps_pkg::REG_GRID_COLS) cols_ff <= csr_wdata;
      end
   end

   always_comb begin
      if (rows_ff == '0) rows_eff = CW'(1);
      else if (SZW'(rows_ff) > SZW'(MAX_SIDE)) rows_eff = CW'(MAX_SIDE);
      else rows_eff = CW'(rows_ff);
      if (cols_ff == '0) cols_eff = CW'(1);
      else if (SZW'(cols_ff) > SZW'(MAX_SIDE)) cols_eff = CW'(MAX_SIDE);
      else cols_eff = CW'(cols_ff);
   end

   // Request fields.
   logic          kind_ff, flag_ff;
   logic [CW-1:0] sr_ff, sc_ff, gr_ff, gc_ff;

   always_ff @(posedge clock) begin
      if (req_load) begin
         kind_ff <= req_tuser;
         sr_ff   <= CW'(req_tdata[4:0]);
         sc_ff   <= CW'(req_tdata[9:5]);
         gr_ff   <= CW'(req_tdata[14:10]);
         gc_ff   <= CW'(req_tdata[19:15]);
         flag_ff <= req_tdata[20];
      end
   end

   // Search registers.
   logic [CW-1:0]         cr_ff, cc_ff;
   logic [COST_WIDTH-1:0] curg_ff, g_ff, h_ff, f_ff, best_f_ff;
   logic [1:0]            ni_ff, nj_ff;
   logic [CNT_W-1:0]      cnt_ff, k_ff, best_k_ff;
   logic [AW-1:0]         clr_ff;
   logic [LW-1:0]         best_rc_ff;
   logic                  b1_ff, b2_ff;

   // Memory read registers.
   logic                  blk_rd_ff;
   logic [1:0]            mark_rd_ff;
   logic [COST_WIDTH-1:0] est_rd_ff, cost_rd_ff;
   logic [LW-1:0]         list_rd_ff;

   logic                  blk_mem  [CELLS];
   logic [1:0]            mark_mem [CELLS];
   logic [COST_WIDTH-1:0] est_mem  [CELLS];
   logic [COST_WIDTH-1:0] cost_mem [CELLS];
   logic [LW-1:0]         list_mem [CELLS];

   // Neighbor under test.
   logic [CW-1:0] nrow, ncol, best_r, best_c, list_r, list_c, hr, hc;
   logic          row_ok, col_ok, in_storage;
   logic [CW:0]   man_dist;
   logic [HW-1:0] h_raw;
   logic [COST_WIDTH-1:0] h_val;
   logic [3:0]    step;
   logic          nb_skip, seen, do_upd, do_add;

   assign nrow   = cr_ff + CW'(ni_ff) - CW'(1);
   assign ncol   = cc_ff + CW'(nj_ff) - CW'(1);
   assign row_ok = (cr_ff != '0 || ni_ff != 2'd0) && nrow < rows_eff;
   assign col_ok = (cc_ff != '0 || nj_ff != 2'd0) && ncol < cols_eff;
   assign best_r = CW'(best_rc_ff[LW-1:IDX_W]);
   assign best_c = CW'(best_rc_ff[IDX_W-1:0]);
   assign list_r = CW'(list_rd_ff[LW-1:IDX_W]);
   assign list_c = CW'(list_rd_ff[IDX_W-1:0]);
   assign in_storage = sr_ff < CW'(MAX_SIDE) && sc_ff < CW'(MAX_SIDE);

   assign hr       = cmd.init_start ? sr_ff : nrow;
   assign hc       = cmd.init_start ? sc_ff : ncol;
   assign man_dist = (CW+1)'((hr > gr_ff) ? hr - gr_ff : gr_ff - hr)
                   + (CW+1)'((hc > gc_ff) ? hc - gc_ff : gc_ff - hc);
   assign h_raw = HW'(man_dist) * HW'(gaps_pkg::HEUR_SCALE);
   assign h_val = sat_cost(SW'(h_raw));
   assign step  = (ni_ff != 2'd1 && nj_ff != 2'd1) ? 4'(gaps_pkg::STEP_DIAG)
                                                   : 4'(gaps_pkg::STEP_STRAIGHT);

   assign nb_skip = b1_ff | b2_ff | blk_rd_ff;
   assign seen    = mark_rd_ff[0] | mark_rd_ff[1];
   assign do_upd  = cmd.eval && !nb_skip && seen && est_rd_ff > f_ff;
   assign do_add  = cmd.eval && !nb_skip && !seen && cnt_ff < CNT_W'(CELLS);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= stat.clr_last ? '0 : clr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init_start) begin
         cr_ff   <= sr_ff;
         cc_ff   <= sc_ff;
         curg_ff <= '0;
         cnt_ff  <= '0;
      end
      if (cmd.nb_first) begin
         ni_ff <= 2'd0;
         nj_ff <= 2'd0;
      end
      if (cmd.nb_next) begin
         if (nj_ff == 2'd2) begin
            nj_ff <= 2'd0;
            ni_ff <= ni_ff + 2'd1;
         end else begin
            nj_ff <= nj_ff + 2'd1;
         end
      end
      if (cmd.rd2) begin
         b1_ff <= blk_rd_ff;
         g_ff  <= sat_cost(SW'(curg_ff) + SW'(step));
         h_ff  <= h_val;
      end
      if (cmd.rd3) begin
         b2_ff <= blk_rd_ff;
         f_ff  <= sat_cost(SW'(g_ff) + SW'(h_ff));
      end
      if (do_add) cnt_ff <= cnt_ff + CNT_W'(1);
      if (cmd.scan_init) k_ff <= '0;
      if (cmd.scan_c) begin
         if (k_ff == '0 || est_rd_ff < best_f_ff) begin
            best_k_ff  <= k_ff;
            best_f_ff  <= est_rd_ff;
            best_rc_ff <= list_rd_ff;
         end
         k_ff <= k_ff + CNT_W'(1);
      end
      if (cmd.mv_init) k_ff <= best_k_ff;
      if (cmd.mv_wr) k_ff <= k_ff + CNT_W'(1);
      if (cmd.pop) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         cr_ff  <= best_r;
         cc_ff  <= best_c;
      end
      if (cmd.pop_wt) curg_ff <= cost_rd_ff;
   end

   // Blocked map: one write port shared by the reset sweep and write requests.
   always_ff @(posedge clock) begin
      if (cmd.clr_step && cmd.clr_blk) begin
         blk_mem[clr_ff] <= 1'b0;
      end else if (cmd.wr_map && in_storage) begin
         blk_mem[cell_addr(sr_ff, sc_ff)] <= flag_ff;
      end
      if (cmd.rd1) blk_rd_ff <= blk_mem[cell_addr(nrow, ncol)];
      else if (cmd.rd2) blk_rd_ff <= blk_mem[cell_addr(cr_ff, ncol)];
      else if (cmd.rd3) blk_rd_ff <= blk_mem[cell_addr(nrow, cc_ff)];
   end

   // Open and closed marks, bit 0 open and bit 1 closed.
   always_ff @(posedge clock) begin
      if (cmd.clr_step) mark_mem[clr_ff] <= 2'b00;
      else if (do_add) mark_mem[cell_addr(nrow, ncol)] <= 2'b01;
      else if (cmd.close_cur) mark_mem[cell_addr(cr_ff, cc_ff)] <= 2'b10;
      if (cmd.rd1) mark_rd_ff <= mark_mem[cell_addr(nrow, ncol)];
   end

   always_ff @(posedge clock) begin
      if (cmd.init_start) est_mem[cell_addr(sr_ff, sc_ff)] <= h_val;
      else if (do_upd || do_add) est_mem[cell_addr(nrow, ncol)] <= f_ff;
      if (cmd.rd1) est_rd_ff <= est_mem[cell_addr(nrow, ncol)];
      else if (cmd.scan_e) est_rd_ff <= est_mem[cell_addr(list_r, list_c)];
   end

   always_ff @(posedge clock) begin
      if (cmd.init_start) cost_mem[cell_addr(sr_ff, sc_ff)] <= '0;
      else if (do_upd || do_add) cost_mem[cell_addr(nrow, ncol)] <= g_ff;
      if (cmd.pop) cost_rd_ff <= cost_mem[cell_addr(best_r, best_c)];
   end

   // Open list in insertion order; removal shifts the tail down one entry a step.
   always_ff @(posedge clock) begin
      if (do_add) list_mem[cnt_ff[AW-1:0]] <= {nrow[IDX_W-1:0], ncol[IDX_W-1:0]};
      else if (cmd.mv_wr) list_mem[k_ff[AW-1:0]] <= list_rd_ff;
      if (cmd.scan_l) list_rd_ff <= list_mem[k_ff[AW-1:0]];
      else if (cmd.mv_rd) list_rd_ff <= list_mem[AW'(k_ff + CNT_W'(1))];
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_tvalid <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_tuser <= cmd.out_code;
         if (cmd.out_code == gaps_pkg::RES_FOUND) begin
            rsp_tdata <= gaps_pkg::RSP_DATA_W'(
               (curg_ff > COST_WIDTH'(65535)) ? gaps_pkg::OUT_COST_W'(65535)
                                              : gaps_pkg::OUT_COST_W'(curg_ff));
         end else begin
            rsp_tdata <= '0;
         end
      end
   end

   always_comb begin
      stat.is_search  = (kind_ff == gaps_pkg::REQ_SEARCH);
      stat.off_grid   = sr_ff >= rows_eff || sc_ff >= cols_eff ||
                        gr_ff >= rows_eff || gc_ff >= cols_eff;
      stat.clr_last   = (clr_ff == AW'(CELLS - 1));
      stat.at_goal    = (cr_ff == gr_ff) && (cc_ff == gc_ff);
      stat.nb_ok      = row_ok && col_ok && !(ni_ff == 2'd1 && nj_ff == 2'd1);
      stat.nb_last    = (ni_ff == 2'd2) && (nj_ff == 2'd2);
      stat.open_empty = (cnt_ff == '0);
      stat.scan_last  = (k_ff + CNT_W'(1) == cnt_ff);
      stat.mv_end     = (k_ff + CNT_W'(1) >= cnt_ff);
      stat.out_free   = !rsp_tvalid || rsp_tready;
   end

endmodule

// ----- rtl/grid_astar_path_search_top.sv -----
// Grid A* path search over an on-chip blocked-cell map.
// Requests enter on req_*: req_tuser selects a blocked-flag write (0) or a search (1).
// One result leaves on rsp_* per request: rsp_tuser holds the status (write done,
// path found, no path) and rsp_tdata the goal's path cost when a path was found.
// The grid size is set through csr_*, by the user only while the block is idle;
// the block itself does not enforce this. A write passes the load, map-write and
// finish states before its result is registered. A search first clears the
// open/closed marks, then runs one expansion per closed cell: a check of each of the
// 9 positions around it, reads and an evaluation for each evaluated neighbor, a scan
// of the open list and a shift of the list tail, all through single-port memories
// sequenced by the controller. Its length therefore depends on the map.
// One request is in work at a time; the next is accepted once the result is in the
// output register, even while that result still waits.
// After reset the blocked map is swept clear before the first request is accepted;
// configuration writes are taken during the sweep.
// When the receiver stalls, the finished result holds and the next result waits.
module grid_astar_path_search_top #(
   parameter int MAX_SIDE   = gaps_pkg::MAX_SIDE_DEF,
   parameter int COST_WIDTH = gaps_pkg::COST_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // first_row[4:0], first_col[9:5], goal_row[14:10], goal_col[19:15], blocked_flag[20]
   input  logic [gaps_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type[0]
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // path_cost[15:0]
   output logic [gaps_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]                      rsp_tuser,
   input  logic                            csr_we,
   input  logic [gaps_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [gaps_pkg::SIZE_W-1:0]     csr_wdata
);

   gaps_pkg::cmd_type  cmd;
   gaps_pkg::stat_type stat;
   logic               req_load;

   assign req_load = req_tvalid && req_tready;

   gaps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   gaps_datapath #(
      .MAX_SIDE   (MAX_SIDE),
      .COST_WIDTH (COST_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_load   (req_load),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat)
   );

   // An accepted request always makes the block busy on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_load |=> !req_tready)
      else $error("block still ready right after accepting a request");

   // A new result is only produced while no request is being accepted.
   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without the block having been busy");

   // The controller never loads a result into an occupied, stalled output register.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result loaded over a pending result");

endmodule

// ----- tb/tb_grid_astar_path_search_top.sv -----
`timescale 1ns / 1ps

module tb_grid_astar_path_search_top;

   localparam int SIDE     = gaps_pkg::MAX_SIDE_DEF;
   localparam int COST_TOP = (1 << gaps_pkg::COST_WIDTH_DEF) - 1;

   class path_scoreboard;
      bit          wall[SIDE*SIDE];
      int unsigned g_cost[SIDE*SIDE];
      int unsigned f_est[SIDE*SIDE];
      bit          in_open[SIDE*SIDE];
      bit          in_closed[SIDE*SIDE];
      int unsigned open_q[$];
      int unsigned rows = gaps_pkg::SIZE_RESET;
      int unsigned cols = gaps_pkg::SIZE_RESET;
      gaps_pkg::result_type exp_status[$];
      int unsigned exp_cost[$];
      int          mismatches = 0;

      function void set_reg(gaps_pkg::reg_index_type idx, bit [gaps_pkg::SIZE_W-1:0] v);
         if (idx == gaps_pkg::REG_GRID_ROWS) rows = 32'(v);
         else cols = 32'(v);
      endfunction

      function int unsigned clip_size(int unsigned v);
         if (v < 1) return 1;
         if (v > SIDE) return SIDE;
         return v;
      endfunction

      function int unsigned sat(int unsigned v);
         return (v > COST_TOP) ? COST_TOP : v;
      endfunction

      function int unsigned manhattan(int unsigned r, int unsigned c, int unsigned gr,
                                      int unsigned gc);
         int unsigned dr, dc;
         dr = (r > gr) ? r - gr : gr - r;
         dc = (c > gc) ? c - gc : gc - c;
         return sat((dr + dc) * gaps_pkg::HEUR_SCALE);
      endfunction

      function void search(int unsigned sr, int unsigned sc, int unsigned gr, int unsigned gc,
                           output gaps_pkg::result_type st, output int unsigned cost);
         int unsigned nr, nc, cr, cc, cur, r0, r1, c0, c1, n, g, f, best;
         nr = clip_size(rows);
         nc = clip_size(cols);
         cost = 0;
         st = gaps_pkg::RES_NO_PATH;
         if (sr >= nr || sc >= nc || gr >= nr || gc >= nc) return;
         foreach (in_open[k]) begin
            in_open[k] = 0;
            in_closed[k] = 0;
         end
         open_q.delete();
         cr = sr;
         cc = sc;
         cur = cr * SIDE + cc;
         g_cost[cur] = 0;
         f_est[cur] = manhattan(cr, cc, gr, gc);
         while (cr != gr || cc != gc) begin
            r0 = (cr > 0) ? cr - 1 : 0;
            r1 = (cr + 2 < nr) ? cr + 2 : nr;
            c0 = (cc > 0) ? cc - 1 : 0;
            c1 = (cc + 2 < nc) ? cc + 2 : nc;
            for (int unsigned i = r0; i < r1; i++) begin
               for (int unsigned j = c0; j < c1; j++) begin
                  n = i * SIDE + j;
                  // Both corner cells must be free; a straight step has itself as a corner.
                  if ((i == cr && j == cc) || wall[n] || wall[cr*SIDE+j] || wall[i*SIDE+cc])
                     continue;
                  g = sat(g_cost[cur] + ((i != cr && j != cc) ? gaps_pkg::STEP_DIAG
                                                              : gaps_pkg::STEP_STRAIGHT));
                  f = sat(g + manhattan(i, j, gr, gc));
                  if (in_open[n] || in_closed[n]) begin
                     if (f_est[n] > f) begin
                        f_est[n] = f;
                        g_cost[n] = g;
                     end
                  end else if (open_q.size() < SIDE*SIDE) begin
                     f_est[n] = f;
                     g_cost[n] = g;
                     in_open[n] = 1;
                     open_q.push_back(n);
                  end
               end
            end
            in_closed[cur] = 1;
            if (open_q.size() == 0) return;
            best = 0;
            for (int unsigned k = 1; k < open_q.size(); k++)
               if (f_est[open_q[k]] < f_est[open_q[best]]) best = k;
            cur = open_q[best];
            open_q.delete(best);
            in_open[cur] = 0;
            cr = cur / SIDE;
            cc = cur % SIDE;
         end
         st = gaps_pkg::RES_FOUND;
         cost = (g_cost[cur] > 65535) ? 65535 : g_cost[cur];
      endfunction

      function void note_request(gaps_pkg::req_kind_type kind, bit [4:0] r, bit [4:0] c,
                                 bit [4:0] gr, bit [4:0] gc, bit flag);
         gaps_pkg::result_type st;
         int unsigned cost;
         if (kind == gaps_pkg::REQ_WRITE) begin
            wall[r*SIDE+c] = flag;
            st = gaps_pkg::RES_WRITE_DONE;
            cost = 0;
         end else begin
            search(r, c, gr, gc, st, cost);
         end
         exp_status.push_back(st);
         exp_cost.push_back(cost);
      endfunction

      function void check_result(logic [1:0] st, logic [gaps_pkg::RSP_DATA_W-1:0] data);
         gaps_pkg::result_type want_st;
         int unsigned want_cost;
         if (exp_status.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result: status %0d cost %0d", st, data);
            return;
         end
         want_st = exp_status.pop_front();
         want_cost = exp_cost.pop_front();
         if (st !== want_st || data !== gaps_pkg::RSP_DATA_W'(want_cost)) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: expected status %0d cost %0d, got status %0d cost %0d",
                        want_st, want_cost, st, data);
         end
      endfunction

      function int pending();
         return exp_status.size();
      endfunction
   endclass

   logic                                clock = 0;
   logic                                reset = 1;
   logic                                req_tvalid = 0;
   logic                                req_tready;
   logic [gaps_pkg::REQ_DATA_W-1:0]     req_tdata = '0;
   logic                                req_tuser = 0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 0;
   logic [gaps_pkg::RSP_DATA_W-1:0]     rsp_tdata;
   logic [1:0]                          rsp_tuser;
   logic                                csr_we = 0;
   logic [gaps_pkg::CSR_ADDR_W-1:0]     csr_addr = '0;
   logic [gaps_pkg::SIZE_W-1:0]         csr_wdata = '0;

   path_scoreboard sb = new();
   bit gaps_on = 0;
   bit long_hold = 0;

   grid_astar_path_search_top i_dut (.*);

   always #4 clock = ~clock;

   initial begin
      #500ms;
      $display("Test completed with failures");
      $finish;
   end

   // Result side: random stalls per request, plus one long hold-off on demand.
   initial begin
      int n;
      @(negedge clock);
      forever begin
         n = gaps_on ? $urandom_range(0, 17) : 0;
         if (long_hold) begin
            long_hold = 0;
            n = 400;
         end
         if (n > 0) begin
            rsp_tready <= 0;
            repeat (n) @(negedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tuser, rsp_tdata);
         @(negedge clock);
      end
   end

   task automatic send(gaps_pkg::req_kind_type kind, bit [4:0] r, bit [4:0] c, bit [4:0] gr,
                       bit [4:0] gc, bit flag);
      int n;
      n = gaps_on ? $urandom_range(0, 17) : 0;
      if (n > 0) begin
         req_tvalid <= 0;
         repeat (n) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= kind;
      req_tdata <= {3'b000, flag, gc, gr, c, r};
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, r, c, gr, gc, flag);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_size(bit [gaps_pkg::SIZE_W-1:0] rows, bit [gaps_pkg::SIZE_W-1:0] cols);
      wait_idle();
      csr_we <= 1;
      csr_addr <= gaps_pkg::REG_GRID_ROWS;
      csr_wdata <= rows;
      @(negedge clock);
      csr_addr <= gaps_pkg::REG_GRID_COLS;
      csr_wdata <= cols;
      @(negedge clock);
      csr_we <= 0;
      sb.set_reg(gaps_pkg::REG_GRID_ROWS, rows);
      sb.set_reg(gaps_pkg::REG_GRID_COLS, cols);
   endtask

   // Mostly in-grid writes and searches; a few requests use any coordinates.
   // On wide grids only short searches are made, so runs stay short.
   task automatic random_phase(int rows, int cols, int count, bit wide);
      int unsigned nr, nc, r, c, gr, gc, pick;
      nr = sb.clip_size(rows);
      nc = sb.clip_size(cols);
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         r = $urandom_range(0, nr - 1);
         c = $urandom_range(0, nc - 1);
         if (wide) begin
            gr = (r + $urandom_range(0, 4) < nr) ? r + $urandom_range(0, 4) : nr - 1;
            gc = (c + $urandom_range(0, 4) < nc) ? c + $urandom_range(0, 4) : nc - 1;
         end else begin
            gr = $urandom_range(0, nr - 1);
            gc = $urandom_range(0, nc - 1);
         end
         if (pick < 8)
            send(gaps_pkg::req_kind_type'($urandom_range(0, 1) & !wide),
                 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                 1'($urandom_range(0, 1)));
         else if (pick < 60)
            send(gaps_pkg::REQ_WRITE, 5'(r), 5'(c), 5'($urandom_range(0, 31)),
                 5'($urandom_range(0, 31)), !wide && $urandom_range(0, 99) < 30);
         else
            send(gaps_pkg::REQ_SEARCH, 5'(r), 5'(c), 5'(gr), 5'(gc),
                 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed requests on the default 20 by 20 grid.
      send(gaps_pkg::REQ_WRITE, 31, 31, 31, 31, 1);
      send(gaps_pkg::REQ_WRITE, 0, 0, 0, 0, 1);
      send(gaps_pkg::REQ_SEARCH, 0, 0, 0, 0, 0);
      send(gaps_pkg::REQ_SEARCH, 0, 0, 2, 2, 0);
      send(gaps_pkg::REQ_SEARCH, 0, 0, 0, 3, 0);
      send(gaps_pkg::REQ_SEARCH, 19, 19, 20, 0, 0);
      send(gaps_pkg::REQ_SEARCH, 31, 0, 0, 0, 1);
      send(gaps_pkg::REQ_WRITE, 0, 0, 31, 31, 0);
      send(gaps_pkg::REQ_SEARCH, 0, 0, 19, 19, 0);
      send(gaps_pkg::REQ_SEARCH, 19, 0, 0, 19, 0);
      send(gaps_pkg::REQ_SEARCH, 31, 31, 31, 31, 0);

      // Corner blocking on a 3 by 3 grid, then a full wall.
      set_size(3, 3);
      send(gaps_pkg::REQ_WRITE, 0, 1, 0, 0, 1);
      send(gaps_pkg::REQ_WRITE, 1, 0, 0, 0, 1);
      send(gaps_pkg::REQ_SEARCH, 0, 0, 1, 1, 0);
      send(gaps_pkg::REQ_SEARCH, 2, 2, 0, 0, 0);
      send(gaps_pkg::REQ_WRITE, 1, 0, 0, 0, 0);
      send(gaps_pkg::REQ_WRITE, 1, 1, 0, 0, 1);
      send(gaps_pkg::REQ_WRITE, 2, 1, 0, 0, 1);
      send(gaps_pkg::REQ_SEARCH, 0, 0, 0, 2, 0);
      send(gaps_pkg::REQ_SEARCH, 0, 0, 2, 0, 0);

      // Register extremes: zero acts as one, above the maximum acts as the maximum.
      set_size(0, 63);
      send(gaps_pkg::REQ_SEARCH, 0, 3, 0, 3, 0);
      send(gaps_pkg::REQ_SEARCH, 0, 2, 0, 31, 0);
      send(gaps_pkg::REQ_SEARCH, 0, 0, 1, 0, 0);

      gaps_on = 1;
      set_size(1, 1);
      random_phase(1, 1, 5, 0);
      set_size(5, 7);
      random_phase(5, 7, 15, 0);
      set_size(8, 8);
      random_phase(8, 8, 15, 0);

      // Long receiver hold-off while requests keep coming.
      long_hold = 1;
      gaps_on = 0;
      random_phase(8, 8, 12, 0);
      gaps_on = 1;

      set_size(4, 12);
      random_phase(4, 12, 20, 0);
      set_size(32, 32);
      random_phase(32, 32, 15, 1);
      send(gaps_pkg::REQ_SEARCH, 31, 31, 24, 26, 0);

      wait_idle();
      repeat (50) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/gaps_pkg.sv
rtl/gaps_ctrl.sv
rtl/gaps_datapath.sv
rtl/grid_astar_path_search_top.sv
tb/tb_grid_astar_path_search_top.sv
